FILE: src/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry.
  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int CELL_W = $clog2(CELLS);

  // Cell index width on the ports, and the width of an index plus a row base.
  localparam int IDX_W = 11;
  localparam int SUM_W = ((IDX_W > CELL_W) ? IDX_W : CELL_W) + 1;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  typedef logic [CELL_W-1:0] cell_addr_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef enum logic [1:0] {
    KIND_PUT       = 2'd0,
    KIND_BACKSPACE = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_READ      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic sweep;
    logic respond;
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
  } tcw_stat_t;

endpackage

FILE: src/tcw_ctrl.sv
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_cmd_t  cmd,
  output logic              busy
);

  tcw_pkg::state_t state_r;
  tcw_pkg::state_t state_nxt;

  // State register; reset starts with the blanking sweep of the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        if (stat.sweep_last) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        state_nxt = stat.need_sweep ? tcw_pkg::ST_SWEEP : tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_SWEEP: begin
        if (stat.sweep_last) begin
          state_nxt = tcw_pkg::ST_RESP;
        end
      end
      tcw_pkg::ST_RESP: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands and busy.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        cmd.sweep = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      tcw_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      tcw_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
      end
      tcw_pkg::ST_RESP: begin
        cmd.respond = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: src/tcw_datapath.sv
module tcw_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  tcw_pkg::tcw_cmd_t  cmd,
  output tcw_pkg::tcw_stat_t stat,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_char_code,
  input  logic [10:0]        in_cell_index,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_text_attribute,
  output logic               out_strobe,
  output logic [10:0]        out_cursor_index,
  output logic [7:0]         out_read_char,
  output logic [7:0]         out_read_attr,
  output logic               out_scrolled
);

  // Cell store: character in the low byte, attribute in the high byte.
  logic [15:0] mem [tcw_pkg::CELLS];

  // Latched item.
  tcw_pkg::kind_t kind_r, kind_nxt;
  logic [7:0]     ch_r, ch_nxt;
  tcw_pkg::idx_t  idx_r, idx_nxt;

  // Cursor, kept as linear index and as row and column.
  tcw_pkg::cell_addr_t lin_r, lin_nxt;
  tcw_pkg::row_t       row_r, row_nxt;
  tcw_pkg::col_t       col_r, col_nxt;

  // Physical start of the top screen row in the store.
  tcw_pkg::cell_addr_t base_r, base_nxt;

  // Blanking sweep.
  tcw_pkg::cell_addr_t sweep_addr_r, sweep_addr_nxt;
  tcw_pkg::cell_addr_t sweep_left_r, sweep_left_nxt;
  logic [7:0]          blank_attr_r, blank_attr_nxt;

  logic [7:0]  attr_r, attr_nxt;
  logic        scr_r, scr_nxt;
  logic        rd_ok_r, rd_ok_nxt;
  logic [15:0] rd_data_r;

  logic        strobe_r, strobe_nxt;
  tcw_pkg::idx_t out_cur_r, out_cur_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic [7:0]  out_attr_r, out_attr_nxt;
  logic        out_scr_r, out_scr_nxt;

  // Memory port controls.
  logic                mem_we;
  tcw_pkg::cell_addr_t mem_waddr;
  logic [15:0]         mem_wdata;
  logic                rd_en;
  tcw_pkg::cell_addr_t rd_addr;

  // Address mapping and cursor arithmetic.
  tcw_pkg::sum_t       cur_sum, idx_sum, base_sum;
  tcw_pkg::cell_addr_t cur_phys, bs_phys, idx_phys, base_step;
  logic                idx_in_range, at_eol, is_nl, wrap;

  always_comb begin
    cur_sum  = tcw_pkg::sum_t'(lin_r) + tcw_pkg::sum_t'(base_r);
    cur_phys = (cur_sum >= tcw_pkg::sum_t'(tcw_pkg::CELLS)) ?
               tcw_pkg::cell_addr_t'(cur_sum - tcw_pkg::sum_t'(tcw_pkg::CELLS)) :
               tcw_pkg::cell_addr_t'(cur_sum);
    bs_phys  = (cur_phys == '0) ? tcw_pkg::cell_addr_t'(tcw_pkg::CELLS - 1) :
               cur_phys - tcw_pkg::cell_addr_t'(1);

    idx_in_range = tcw_pkg::sum_t'(idx_r) < tcw_pkg::sum_t'(tcw_pkg::CELLS);
    idx_sum  = tcw_pkg::sum_t'(idx_r) + tcw_pkg::sum_t'(base_r);
    if (!idx_in_range) begin
      idx_phys = '0;
    end else if (idx_sum >= tcw_pkg::sum_t'(tcw_pkg::CELLS)) begin
      idx_phys = tcw_pkg::cell_addr_t'(idx_sum - tcw_pkg::sum_t'(tcw_pkg::CELLS));
    end else begin
      idx_phys = tcw_pkg::cell_addr_t'(idx_sum);
    end

    base_sum  = tcw_pkg::sum_t'(base_r) + tcw_pkg::sum_t'(tcw_pkg::COLS);
    base_step = (base_sum >= tcw_pkg::sum_t'(tcw_pkg::CELLS)) ? '0 :
                tcw_pkg::cell_addr_t'(base_sum);

    is_nl  = (ch_r == tcw_pkg::NEWLINE_CHAR);
    at_eol = (col_r == tcw_pkg::col_t'(tcw_pkg::COLS - 1));
    wrap   = (row_r == tcw_pkg::row_t'(tcw_pkg::ROWS - 1)) && (is_nl || at_eol);
  end

  assign stat.need_sweep = (kind_r == tcw_pkg::KIND_CLEAR) ||
                           ((kind_r == tcw_pkg::KIND_PUT) && wrap);
  assign stat.sweep_last = (sweep_left_r == '0);

  // Next-state logic for the whole datapath.
  always_comb begin
    kind_nxt       = kind_r;
    ch_nxt         = ch_r;
    idx_nxt        = idx_r;
    lin_nxt        = lin_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    base_nxt       = base_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_left_nxt = sweep_left_r;
    blank_attr_nxt = blank_attr_r;
    attr_nxt       = cfg_we ? cfg_text_attribute : attr_r;
    scr_nxt        = scr_r;
    rd_ok_nxt      = rd_ok_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_phys;
    mem_wdata      = {attr_r, ch_r};
    rd_en          = 1'b0;
    rd_addr        = idx_phys;
    strobe_nxt     = cmd.respond;
    out_cur_nxt    = out_cur_r;
    out_char_nxt   = out_char_r;
    out_attr_nxt   = out_attr_r;
    out_scr_nxt    = out_scr_r;

    // Latch an accepted word.
    if (cmd.load) begin
      kind_nxt = tcw_pkg::kind_t'(in_kind);
      ch_nxt   = in_char_code;
      idx_nxt  = in_cell_index;
    end

    // Carry out the item.
    if (cmd.exec) begin
      scr_nxt = 1'b0;
      case (kind_r)
        tcw_pkg::KIND_PUT: begin
          if (!is_nl) begin
            mem_we    = 1'b1;
            mem_waddr = cur_phys;
            mem_wdata = {attr_r, ch_r};
          end
          if (wrap) begin
            // Scroll: rotate the row base and blank the old top row.
            lin_nxt        = tcw_pkg::cell_addr_t'(tcw_pkg::CELLS - tcw_pkg::COLS);
            row_nxt        = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
            col_nxt        = '0;
            base_nxt       = base_step;
            sweep_addr_nxt = base_r;
            sweep_left_nxt = tcw_pkg::cell_addr_t'(tcw_pkg::COLS - 1);
            blank_attr_nxt = attr_r;
            scr_nxt        = 1'b1;
          end else if (is_nl || at_eol) begin
            lin_nxt = lin_r - tcw_pkg::cell_addr_t'(col_r) +
                      tcw_pkg::cell_addr_t'(tcw_pkg::COLS);
            row_nxt = row_r + tcw_pkg::row_t'(1);
            col_nxt = '0;
          end else begin
            lin_nxt = lin_r + tcw_pkg::cell_addr_t'(1);
            col_nxt = col_r + tcw_pkg::col_t'(1);
          end
        end
        tcw_pkg::KIND_BACKSPACE: begin
          if (lin_r != '0) begin
            mem_we    = 1'b1;
            mem_waddr = bs_phys;
            mem_wdata = {attr_r, tcw_pkg::BLANK_CHAR};
            lin_nxt   = lin_r - tcw_pkg::cell_addr_t'(1);
            if (col_r == '0) begin
              col_nxt = tcw_pkg::col_t'(tcw_pkg::COLS - 1);
              row_nxt = row_r - tcw_pkg::row_t'(1);
            end else begin
              col_nxt = col_r - tcw_pkg::col_t'(1);
            end
          end
        end
        tcw_pkg::KIND_CLEAR: begin
          lin_nxt        = '0;
          row_nxt        = '0;
          col_nxt        = '0;
          base_nxt       = '0;
          sweep_addr_nxt = '0;
          sweep_left_nxt = tcw_pkg::cell_addr_t'(tcw_pkg::CELLS - 1);
          blank_attr_nxt = attr_r;
        end
        tcw_pkg::KIND_READ: begin
          rd_en     = 1'b1;
          rd_ok_nxt = idx_in_range;
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end

    // One blank cell per cycle during a sweep.
    if (cmd.sweep) begin
      mem_we         = 1'b1;
      mem_waddr      = sweep_addr_r;
      mem_wdata      = {blank_attr_r, tcw_pkg::BLANK_CHAR};
      sweep_addr_nxt = sweep_addr_r + tcw_pkg::cell_addr_t'(1);
      sweep_left_nxt = sweep_left_r - tcw_pkg::cell_addr_t'(1);
    end

    // Load the result word.
    if (cmd.respond) begin
      out_cur_nxt = tcw_pkg::idx_t'(lin_r);
      out_scr_nxt = scr_r;
      if ((kind_r == tcw_pkg::KIND_READ) && rd_ok_r) begin
        out_char_nxt = rd_data_r[7:0];
        out_attr_nxt = rd_data_r[15:8];
      end else begin
        out_char_nxt = '0;
        out_attr_nxt = '0;
      end
    end
  end

  // Control and cursor registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r        <= '0;
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
      sweep_addr_r <= '0;
      sweep_left_r <= tcw_pkg::cell_addr_t'(tcw_pkg::CELLS - 1);
      blank_attr_r <= tcw_pkg::RESET_ATTR;
      attr_r       <= tcw_pkg::RESET_ATTR;
      scr_r        <= 1'b0;
      rd_ok_r      <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      lin_r        <= lin_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      base_r       <= base_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_left_r <= sweep_left_nxt;
      blank_attr_r <= blank_attr_nxt;
      attr_r       <= attr_nxt;
      scr_r        <= scr_nxt;
      rd_ok_r      <= rd_ok_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    ch_r       <= ch_nxt;
    idx_r      <= idx_nxt;
    out_cur_r  <= out_cur_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  // Cell store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_strobe       = strobe_r;
  assign out_cursor_index = out_cur_r;
  assign out_read_char    = out_char_r;
  assign out_read_attr    = out_attr_r;
  assign out_scrolled     = out_scr_r;

endmodule

FILE: src/text_console_writer.sv
// Text console over a 25 by 80 cell store (character plus attribute per cell).
// Command channel: an item (in_kind, in_char_code, in_cell_index) is taken at a
// rising edge where start is high and busy is low. Kinds: put character
// (10 is newline), backspace, clear screen, read cell.
// Result channel: one word per item, shown for exactly one cycle while
// out_strobe is high; the receiver cannot hold it off.
// Configuration: cfg_text_attribute is written when cfg_valid and cfg_ready
// are high; cfg_ready is always high. Write it only while the block is idle.
// Sequence: an item passes EXEC, then SWEEP if needed, then RESP; the result word
// is then registered on the ports and busy drops with it; items never overlap.
// A scroll blanks COLS (80) cells and a clear blanks ROWS*COLS (2000) cells:
// both are blanking sweeps through the single write port of the cell store.
// Scrolling does not move cells; the row base rotates, so only one row is
// rewritten.
// Reset: a sweep of all 2000 cells blanks the store with attribute 0x0F, with
// busy high throughout; the cursor is homed and the attribute is 0x0F.
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  output logic        out_strobe,
  output logic [10:0] out_cursor_index,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr,
  output logic        out_scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_text_attribute
);

  tcw_pkg::tcw_cmd_t  cmd;
  tcw_pkg::tcw_stat_t stat;

  // The attribute register takes a word in any cycle.
  assign cfg_ready = 1'b1;

  // Controller.
  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath with the cell store.
  tcw_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .cfg_we             (cfg_valid & cfg_ready),
    .cfg_text_attribute (cfg_text_attribute),
    .out_strobe         (out_strobe),
    .out_cursor_index   (out_cursor_index),
    .out_read_char      (out_read_char),
    .out_read_attr      (out_read_attr),
    .out_scrolled       (out_scrolled)
  );

endmodule

FILE: tb/tb_text_console_writer.sv
module tb_text_console_writer;
  import tcw_pkg::*;

  // One character cell as the console stores it.
  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] code;
  } cell_t;

  // One result word as it leaves the block.
  typedef struct packed {
    idx_t       cursor;
    logic [7:0] rd_char;
    logic [7:0] rd_attr;
    logic       scrolled;
  } console_word_t;

  // Mirror of the console screen that predicts and checks every result word.
  class screen_mirror;
    cell_t         screen [CELLS];
    int unsigned   cursor;
    logic [7:0]    text_attr;
    console_word_t due_words [$];
    int unsigned   errors;
    int unsigned   words_checked;
    int unsigned   scroll_count;
    int unsigned   read_count;

    function cell_t blank_cell();
      return '{attr: text_attr, code: BLANK_CHAR};
    endfunction

    function void blank_cells(int unsigned from, int unsigned upto);
      for (int unsigned i = from; i < upto; i++) screen[i] = blank_cell();
    endfunction

    // State right after reset: blank screen, default attribute, cursor home.
    function void power_on();
      text_attr = RESET_ATTR;
      blank_cells(0, CELLS);
      cursor = 0;
      errors = 0;
      words_checked = 0;
      scroll_count = 0;
      read_count = 0;
    endfunction

    // Applies one accepted command word and queues the word it must produce.
    function void note_item(kind_t k, logic [7:0] c, idx_t ix);
      console_word_t w;
      w = '0;
      case (k)
        KIND_PUT: begin
          if (c == NEWLINE_CHAR) begin
            cursor = (cursor / COLS + 1) * COLS;
          end else begin
            screen[cursor] = '{attr: text_attr, code: c};
            cursor++;
          end
          // Past the last cell: move every row up and blank the bottom one.
          if (cursor >= CELLS) begin
            for (int unsigned i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            blank_cells(CELLS - COLS, CELLS);
            cursor = CELLS - COLS;
            w.scrolled = 1'b1;
            scroll_count++;
          end
        end
        KIND_BACKSPACE: begin
          if (cursor > 0) begin
            cursor--;
            screen[cursor] = blank_cell();
          end
        end
        KIND_CLEAR: begin
          blank_cells(0, CELLS);
          cursor = 0;
        end
        default: begin
          read_count++;
          if (ix < CELLS) begin
            w.rd_char = screen[ix].code;
            w.rd_attr = screen[ix].attr;
          end
        end
      endcase
      w.cursor = idx_t'(cursor);
      due_words.push_back(w);
    endfunction

    // Compares one result word with the oldest prediction.
    function void check_word(idx_t cur, logic [7:0] rc, logic [7:0] ra, logic sc);
      console_word_t want;
      if (due_words.size() == 0) begin
        $error("result word with none expected: cursor_index %0d", cur);
        errors++;
        return;
      end
      want = due_words.pop_front();
      words_checked++;
      if (cur !== want.cursor) begin
        $error("cursor_index: expected %0d, got %0d", want.cursor, cur);
        errors++;
      end
      if (rc !== want.rd_char) begin
        $error("read_char: expected %0d, got %0d", want.rd_char, rc);
        errors++;
      end
      if (ra !== want.rd_attr) begin
        $error("read_attr: expected %0d, got %0d", want.rd_attr, ra);
        errors++;
      end
      if (sc !== want.scrolled) begin
        $error("scrolled: expected %0d, got %0d", want.scrolled, sc);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = KIND_PUT;
  logic [7:0]  in_char_code = '0;
  logic [10:0] in_cell_index = '0;
  logic        out_strobe;
  logic [10:0] out_cursor_index;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attr;
  logic        out_scrolled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_text_attribute = '0;

  screen_mirror mirror;
  int unsigned  items_sent = 0;
  int unsigned  attr_settings = 0;
  int unsigned  burst_left = 0;
  logic         gaps_on = 1'b0;
  logic [7:0]   attr_plan [8];

  text_console_writer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_char_code       (in_char_code),
    .in_cell_index      (in_cell_index),
    .out_strobe         (out_strobe),
    .out_cursor_index   (out_cursor_index),
    .out_read_char      (out_read_char),
    .out_read_attr      (out_read_attr),
    .out_scrolled       (out_scrolled),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_text_attribute (cfg_text_attribute)
  );

  always #5 clk = ~clk;

  // Every strobed result word is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      mirror.check_word(out_cursor_index, out_read_char, out_read_attr, out_scrolled);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic idx_t rand_index();
    return idx_t'($urandom_range(0, 2047));
  endfunction

  // Half of the reads land just behind the cursor, where text was recently written.
  function automatic idx_t pick_read_index();
    int unsigned back;
    case ($urandom_range(0, 9))
      0: return idx_t'($urandom_range(CELLS, 2047));
      1: return rand_index();
      2, 3, 4: return idx_t'($urandom_range(0, CELLS - 1));
      default: begin
        back = $urandom_range(0, 100);
        return idx_t'((mirror.cursor > back) ? mirror.cursor - back : 0);
      end
    endcase
  endfunction

  task automatic pause(int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Sends one command word, with random gaps between bursts when enabled.
  task automatic send_item(kind_t k, logic [7:0] c, idx_t ix);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        pause(($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6));
      end
    end
    burst_left--;
    start <= 1'b1;
    in_kind <= k;
    in_char_code <= c;
    in_cell_index <= ix;
    do @(posedge clk); while (busy);
    mirror.note_item(k, c, ix);
    items_sent++;
  endtask

  // Waits until every predicted word has come back and the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (mirror.due_words.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_attr(logic [7:0] a);
    cfg_valid <= 1'b1;
    cfg_text_attribute <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.text_attr = a;
    attr_settings++;
  endtask

  // Random traffic built from text lines, newline runs, backspaces, reads and clears.
  task automatic run_phase(int unsigned n);
    int unsigned target;
    int unsigned len;
    int unsigned pick;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(KIND_CLEAR, rand_byte(), rand_index());
      end else if (pick < 40) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        repeat (len) send_item(KIND_PUT, rand_byte(), rand_index());
        if ($urandom_range(0, 9) < 7) send_item(KIND_PUT, NEWLINE_CHAR, rand_index());
      end else if (pick < 55) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 8);
        repeat (len) send_item(KIND_PUT, NEWLINE_CHAR, rand_index());
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 6)) send_item(KIND_BACKSPACE, rand_byte(), rand_index());
      end else begin
        repeat ($urandom_range(1, 6)) send_item(KIND_READ, rand_byte(), pick_read_index());
      end
    end
  endtask

  initial begin
    mirror = new;
    mirror.power_on();
    attr_plan = '{8'h00, 8'hFF, rand_byte(), 8'hA5, rand_byte(), 8'h5A, rand_byte(), 8'h0F};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The block blanks its store after reset; wait for that sweep to end.
    while (!busy) @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: reset contents, store edges, backspace at home, odd characters.
    send_item(KIND_READ, 8'h00, idx_t'(0));
    send_item(KIND_READ, 8'hFF, idx_t'(CELLS - 1));
    send_item(KIND_READ, 8'h00, idx_t'(CELLS));
    send_item(KIND_READ, 8'h00, idx_t'(2047));
    send_item(KIND_BACKSPACE, 8'h00, idx_t'(0));
    send_item(KIND_PUT, 8'h00, idx_t'(2047));
    send_item(KIND_PUT, 8'hFF, idx_t'(0));
    send_item(KIND_PUT, 8'h41, idx_t'(0));
    send_item(KIND_READ, 8'h00, idx_t'(0));
    send_item(KIND_READ, 8'h00, idx_t'(1));
    send_item(KIND_READ, 8'h00, idx_t'(2));
    send_item(KIND_BACKSPACE, 8'h00, idx_t'(0));
    send_item(KIND_READ, 8'h00, idx_t'(2));
    send_item(KIND_PUT, NEWLINE_CHAR, idx_t'(0));
    send_item(KIND_BACKSPACE, 8'h00, idx_t'(0));
    send_item(KIND_READ, 8'h00, idx_t'(COLS - 1));
    send_item(KIND_CLEAR, 8'hFF, idx_t'(2047));
    send_item(KIND_READ, 8'h00, idx_t'(0));

    // Random phases, each under its own attribute and idling pattern.
    for (int p = 0; p < 8; p++) begin
      drain();
      set_attr(attr_plan[p]);
      gaps_on = (p % 3 != 1);
      run_phase(200);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d command words under %0d attribute settings; checked %0d results.",
             items_sent, attr_settings, mirror.words_checked);
    $display("Covered %0d scrolls and %0d cell reads; %0d mismatches.",
             mirror.scroll_count, mirror.read_count, mirror.errors);
    if (mirror.errors == 0 && mirror.due_words.size() == 0) begin
      $display("tb_text_console_writer passed");
    end else begin
      $display("tb_text_console_writer failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10_000_000;
    $display("tb_text_console_writer failed");
    $finish;
  end

endmodule
